FILE: design/bitmap_block_allocator_assert.svh
// ---------------------------------------------------------------------------
// bitmap_block_allocator_assert.svh
// assertion macros used by the allocator controller (bba_ctrl)
// ---------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BBA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bba assertion failed");

// antecedent implies consequent in the next cycle
`define BBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bba assertion failed");

`endif

FILE: design/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// constants, types and helpers of the bitmap block allocator
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int BLOCK_BYTES    = 512;
   localparam int MAX_MAP_BLOCKS = 4;
   localparam int MAP_BYTES      = MAX_MAP_BLOCKS * BLOCK_BYTES;
   localparam int FIELD_BYTES    = 2048;
   localparam int CAP_BYTES      = (MAP_BYTES < FIELD_BYTES) ? MAP_BYTES : FIELD_BYTES;
   localparam int BITS_PER_BYTE  = 8;

   localparam int MEM_AW   = $clog2(MAP_BYTES);
   localparam int RANGE_W  = $clog2(CAP_BYTES + 1);
   localparam int PROD_W   = $clog2(MAX_MAP_BLOCKS * BLOCK_BYTES + 1);
   localparam int MSAT_W   = $clog2(MAX_MAP_BLOCKS + 1);
   localparam int MAPC_W   = 3;
   localparam int BLK_W    = 14;
   localparam int STATUS_W = 2;
   localparam int BIT_W    = $clog2(BITS_PER_BYTE);

   localparam logic [7:0] FULL_BYTE = 8'hFF;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   // managed window of the bitmap, derived from the map count register
   typedef struct packed {
      logic [RANGE_W-1:0] bytes;
      logic [RANGE_W-1:0] first;
   } range_type;

   // index of the lowest clear bit of a byte that is not full
   function automatic logic [BIT_W-1:0] lowest_clear(input logic [7:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
         if (!v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: design/bba_ram.sv
// ---------------------------------------------------------------------------
// bba_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// sequencer: clearing pass, first-fit scan and free read-modify-write
// ---------------------------------------------------------------------------
`default_nettype none
`include "bitmap_block_allocator_assert.svh"

module bba_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bba_pkg::range_type             range,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_cmd,
   input  wire logic [bba_pkg::BLK_W-1:0]      req_block_number,
   output logic                                rsp_valid,
   output logic      [bba_pkg::BLK_W-1:0]      rsp_allocated_block,
   output logic      [bba_pkg::STATUS_W-1:0]   rsp_status
);

   bba_pkg::state_type state_ff, state_in;

   logic [bba_pkg::RANGE_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bba_pkg::RANGE_W-1:0]  chk_ptr_ff, chk_ptr_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [bba_pkg::MEM_AW-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [bba_pkg::BIT_W-1:0]    bit_ff, bit_in;
   logic [bba_pkg::BLK_W-1:0]    blk_ff, blk_in;
   logic [bba_pkg::STATUS_W-1:0] status_ff, status_in;

   logic                        wr_en, rd_en;
   logic [bba_pkg::MEM_AW-1:0]  wr_addr, rd_addr;
   logic [7:0]                  wr_data, rd_data;

   logic                        accept, found, exhausted, clr_last;
   logic [bba_pkg::RANGE_W-1:0] req_byte;
   logic [bba_pkg::BIT_W-1:0]   hit_bit;

   bba_ram #(
      .DEPTH (bba_pkg::MAP_BYTES),
      .WIDTH (8)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = start && (state_ff == bba_pkg::ST_IDLE);
   assign req_byte  = bba_pkg::RANGE_W'(req_block_number[bba_pkg::BLK_W-1:bba_pkg::BIT_W]);
   assign found     = chk_vld_ff && (rd_data != bba_pkg::FULL_BYTE);
   // nothing in flight and nothing left to read
   assign exhausted = !chk_vld_ff && (rd_ptr_ff >= range.bytes);
   assign clr_last  = (clr_ptr_ff == bba_pkg::MEM_AW'(bba_pkg::MAP_BYTES - 1));
   assign hit_bit   = bba_pkg::lowest_clear(rd_data);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == bba_pkg::CMD_ALLOC) begin
                  state_in = (range.first >= range.bytes) ? bba_pkg::ST_DONE
                                                          : bba_pkg::ST_SCAN;
               end else begin
                  state_in = (req_byte >= range.bytes) ? bba_pkg::ST_DONE
                                                       : bba_pkg::ST_FREE_WR;
               end
            end
         end
         bba_pkg::ST_SCAN: begin
            if (found || exhausted) begin
               state_in = bba_pkg::ST_DONE;
            end
         end
         bba_pkg::ST_FREE_WR: begin
            state_in = bba_pkg::ST_DONE;
         end
         bba_pkg::ST_DONE: begin
            state_in = bba_pkg::ST_IDLE;
         end
         default: begin
            state_in = bba_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = clr_ptr_ff;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = rd_ptr_ff[bba_pkg::MEM_AW-1:0];
      rd_ptr_in  = rd_ptr_ff;
      chk_ptr_in = chk_ptr_ff;
      chk_vld_in = chk_vld_ff;
      clr_ptr_in = clr_ptr_ff;
      bit_in     = bit_ff;
      blk_in     = blk_ff;
      status_in  = status_ff;
      busy       = (state_ff != bba_pkg::ST_IDLE);
      rsp_valid  = (state_ff == bba_pkg::ST_DONE);
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            wr_en      = 1'b1;
            clr_ptr_in = clr_ptr_ff + 1'b1;
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               blk_in = '0;
               if (req_cmd == bba_pkg::CMD_ALLOC) begin
                  rd_ptr_in  = range.first;
                  chk_vld_in = 1'b0;
                  status_in  = (range.first >= range.bytes) ? bba_pkg::STATUS_FULL
                                                            : bba_pkg::STATUS_OK;
               end else if (req_byte >= range.bytes) begin
                  status_in = bba_pkg::STATUS_RANGE;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = req_byte[bba_pkg::MEM_AW-1:0];
                  chk_ptr_in = req_byte;
                  bit_in     = req_block_number[bba_pkg::BIT_W-1:0];
                  status_in  = bba_pkg::STATUS_OK;
               end
            end
         end
         bba_pkg::ST_SCAN: begin
            if (found) begin
               wr_en     = 1'b1;
               wr_addr   = chk_ptr_ff[bba_pkg::MEM_AW-1:0];
               wr_data   = rd_data | (8'd1 << hit_bit);
               blk_in    = bba_pkg::BLK_W'({chk_ptr_ff, hit_bit});
               status_in = bba_pkg::STATUS_OK;
            end else if (exhausted) begin
               blk_in    = '0;
               status_in = bba_pkg::STATUS_FULL;
            end else begin
               // keep one read in flight ahead of the byte under check
               rd_en      = (rd_ptr_ff < range.bytes);
               chk_ptr_in = rd_ptr_ff;
               chk_vld_in = rd_en;
               if (rd_en) begin
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
            end
         end
         bba_pkg::ST_FREE_WR: begin
            wr_en   = 1'b1;
            wr_addr = chk_ptr_ff[bba_pkg::MEM_AW-1:0];
            wr_data = rd_data & ~(8'd1 << bit_ff);
         end
         bba_pkg::ST_DONE: begin
            chk_vld_in = 1'b0;
         end
         default: begin
            chk_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bba_pkg::ST_CLEAR;
         clr_ptr_ff <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      chk_ptr_ff <= chk_ptr_in;
      bit_ff     <= bit_in;
      blk_ff     <= blk_in;
      status_ff  <= status_in;
   end

   assign rsp_allocated_block = blk_ff;
   assign rsp_status          = status_ff;

   `BBA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `BBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `BBA_ASSERT_SAME(a_no_rw_clash, clock, reset, wr_en, !rd_en)
   `BBA_ASSERT_SAME(a_scan_in_range, clock, reset, wr_en && (state_ff == bba_pkg::ST_SCAN), chk_ptr_ff < range.bytes)
   `BBA_ASSERT_SAME(a_grant_ok, clock, reset, rsp_valid && (rsp_status == bba_pkg::STATUS_OK) && (rsp_allocated_block != '0), rsp_allocated_block[bba_pkg::BLK_W-1:bba_pkg::BIT_W] != '0)

endmodule

`default_nettype wire

FILE: design/bitmap_block_allocator.sv
// allocate: bytes are scanned in turn from the first managed byte, up to 2047 of them;
//   the first free bit found is set and granted, else full status; empty range: full status
// free: result follows the read, then the write back; out of range: range status, no access
// one transaction at a time; busy stays high until the result cycle has passed
// after reset a clearing pass writes all 2048 bitmap bytes, busy high while it runs
// results are shown for one cycle only; the receiver cannot stall
// ---------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a free-block bitmap held in ram
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_cmd,
   input  wire logic [bba_pkg::BLK_W-1:0]     req_block_number,
   output logic                               rsp_valid,
   output logic      [bba_pkg::BLK_W-1:0]     rsp_allocated_block,
   output logic      [bba_pkg::STATUS_W-1:0]  rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bba_pkg::MAPC_W-1:0]    csr_map_blocks
);

   logic [bba_pkg::MAPC_W-1:0] map_blocks_ff;
   logic [bba_pkg::MSAT_W-1:0] maps_sat;
   logic [bba_pkg::PROD_W-1:0] prod;
   bba_pkg::range_type         range;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_blocks_ff <= bba_pkg::MAPC_W'(1);
      end else if (csr_valid && csr_ready) begin
         map_blocks_ff <= csr_map_blocks;
      end
   end

   // managed bytes = min(maps, max) * block bytes, capped by the field width
   always_comb begin
      if (int'(map_blocks_ff) > bba_pkg::MAX_MAP_BLOCKS) begin
         maps_sat = bba_pkg::MSAT_W'(bba_pkg::MAX_MAP_BLOCKS);
      end else begin
         maps_sat = bba_pkg::MSAT_W'(map_blocks_ff);
      end
      prod = bba_pkg::PROD_W'(maps_sat) * bba_pkg::PROD_W'(bba_pkg::BLOCK_BYTES);
      if (prod > bba_pkg::PROD_W'(bba_pkg::CAP_BYTES)) begin
         range.bytes = bba_pkg::RANGE_W'(bba_pkg::CAP_BYTES);
      end else begin
         range.bytes = bba_pkg::RANGE_W'(prod);
      end
      range.first = bba_pkg::RANGE_W'(maps_sat >> 3) + 1'b1;
   end

   bba_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .range               (range),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status)
   );

endmodule

`default_nettype wire
